// ===== rtl/tcpq_pkg.sv =====
`timescale 1ns / 1ps
package tcpq_pkg;

	localparam int QUEUE_DEPTH = 64;
	localparam int MAX_BATCH   = 64;

	localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
	localparam int LIM_W  = 7;
	localparam int LVL_W  = 7;
	localparam int ID_W   = 47;
	localparam int TIME_W = 16;
	localparam int CNT_W  = 32;
	localparam int ENTRY_W = 64;

	localparam logic [1:0] ACT_ADD   = 2'd0;
	localparam logic [1:0] ACT_SERVE = 2'd1;
	localparam logic [1:0] ACT_TICK  = 2'd2;
	localparam logic [1:0] ACT_SET   = 2'd3;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_BAD_ID = 2'd1;
	localparam logic [1:0] ST_FULL   = 2'd2;

	typedef logic [PTR_W-1:0]  ptr_t;
	typedef logic [FILL_W-1:0] fill_t;

	typedef struct packed {
		logic [1:0]          action;
		logic [ID_W-1:0]     entry_id;
		logic                id_valid;
		logic [TIME_W-1:0]   arrival_time;
		logic                gender;
		logic                is_urgent;
		logic [LIM_W-1:0]    serve_limit;
		logic signed [15:0]  countdown_value;
	} in_item_t;

	typedef struct packed {
		logic [ID_W-1:0]   out_id;
		logic [TIME_W-1:0] out_arrival;
		logic              out_gender;
		logic              out_urgent;
		logic              served_valid;
		logic              last_result;
		logic [1:0]        status;
		logic [LVL_W-1:0]  urgent_level;
		logic [LVL_W-1:0]  normal_level;
		logic [CNT_W-1:0]  served_total;
		logic [CNT_W-1:0]  waiting_total;
	} out_item_t;

	typedef struct packed {
		logic              gender;
		logic [TIME_W-1:0] arrival;
		logic [ID_W-1:0]   id;
	} entry_t;

	typedef struct packed {
		logic load_in;
		logic push;
		logic tick;
		logic set;
		logic pop;
		logic emit_blank;
		logic emit_entry;
	} dp_cmd_t;

	typedef struct packed {
		logic [1:0] action;
		logic       cd_zero;
		logic       limit_zero;
		logic       both_empty;
		logic       last;
		logic       out_free;
	} dp_sts_t;

	function automatic ptr_t ptr_next(ptr_t p);
		return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

endpackage

// ===== rtl/two_class_priority_queue_server.sv =====
`timescale 1ns / 1ps
// Add, tick and set load the item into the input register on acceptance, then register
// their result in the output register once it is free; a serve batch reads each entry
// through the registered read port of the queue RAM into the output register, in turn.
// A new item is accepted only in the idle state, once every result of the last is registered.
// Reset (arst_n low, asynchronous): queues empty, countdown and counters zero.
// Queue RAM contents are not cleared; no clearing pass is run.
module two_class_priority_queue_server (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_ready,
	input  tcpq_pkg::in_item_t  item,
	output logic                result_valid,
	input  logic                result_ready,
	output tcpq_pkg::out_item_t result
);
	import tcpq_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	tcpq_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.sts        (sts),
		.cmd        (cmd)
	);

	tcpq_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.cmd          (cmd),
		.sts          (sts),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);
endmodule

// ===== rtl/tcpq_ram.sv =====
`timescale 1ns / 1ps
module tcpq_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic                                       re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// ===== rtl/tcpq_ctrl.sv =====
`timescale 1ns / 1ps
module tcpq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  tcpq_pkg::dp_sts_t sts,
	output tcpq_pkg::dp_cmd_t cmd
);
	import tcpq_pkg::*;

	typedef enum logic [1:0] {S_IDLE, S_EXEC, S_POP, S_EMIT} state_t;
	state_t state_q, state_d;

	assign item_ready = (state_q == S_IDLE);

	always_comb begin
		cmd = '0;
		state_d = state_q;
		cmd.load_in = item_valid && item_ready;
		case (state_q)
			S_IDLE: begin
				if (item_valid) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				if (sts.out_free) begin
					case (sts.action)
						ACT_ADD: begin
							cmd.push = 1'b1;
							cmd.emit_blank = 1'b1;
							state_d = S_IDLE;
						end
						ACT_TICK: begin
							cmd.tick = 1'b1;
							cmd.emit_blank = 1'b1;
							state_d = S_IDLE;
						end
						ACT_SET: begin
							cmd.set = 1'b1;
							cmd.emit_blank = 1'b1;
							state_d = S_IDLE;
						end
						default: begin
							if (!sts.cd_zero || sts.limit_zero || sts.both_empty) begin
								cmd.emit_blank = 1'b1;
								state_d = S_IDLE;
							end else begin
								state_d = S_POP;
							end
						end
					endcase
				end
			end
			S_POP: begin
				cmd.pop = 1'b1;
				state_d = S_EMIT;
			end
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.emit_entry = 1'b1;
					state_d = sts.last ? S_IDLE : S_POP;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end
endmodule

// ===== rtl/tcpq_dp.sv =====
`timescale 1ns / 1ps
module tcpq_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  tcpq_pkg::in_item_t  item,
	input  tcpq_pkg::dp_cmd_t   cmd,
	output tcpq_pkg::dp_sts_t   sts,
	output logic                result_valid,
	input  logic                result_ready,
	output tcpq_pkg::out_item_t result
);
	import tcpq_pkg::*;

	in_item_t          in_q;
	logic [LIM_W-1:0]  limit_q;
	logic [LIM_W-1:0]  cnt_q;
	logic              urg_q;
	logic              last_q;
	ptr_t              u_head_q, u_tail_q, n_head_q, n_tail_q;
	fill_t             u_fill_q, n_fill_q, u_fill_d, n_fill_d;
	logic signed [15:0] cd_q;
	logic [CNT_W-1:0]  served_q, served_d, tick_q, tick_d;
	logic              sel_full, push_ok, u_we, n_we, pop_urg, u_re, n_re, out_free;
	logic [1:0]        add_status;
	logic [ENTRY_W-1:0] u_rdata, n_rdata;
	entry_t            wr_entry, rd_entry;

	assign sel_full = in_q.is_urgent ? (u_fill_q == FILL_W'(QUEUE_DEPTH))
	                                 : (n_fill_q == FILL_W'(QUEUE_DEPTH));
	assign push_ok  = cmd.push && in_q.id_valid && !sel_full;
	assign u_we     = push_ok && in_q.is_urgent;
	assign n_we     = push_ok && !in_q.is_urgent;
	assign pop_urg  = (u_fill_q != '0);
	assign u_re     = cmd.pop && pop_urg;
	assign n_re     = cmd.pop && !pop_urg;
	assign out_free = !result_valid || result_ready;

	assign wr_entry = '{gender: in_q.gender, arrival: in_q.arrival_time, id: in_q.entry_id};
	assign rd_entry = entry_t'(urg_q ? u_rdata : n_rdata);

	always_comb begin
		if (!in_q.id_valid) begin
			add_status = ST_BAD_ID;
		end else if (sel_full) begin
			add_status = ST_FULL;
		end else begin
			add_status = ST_OK;
		end
	end

	always_comb begin
		u_fill_d = u_fill_q;
		n_fill_d = n_fill_q;
		if (u_we) begin
			u_fill_d = u_fill_q + 1'b1;
		end
		if (n_we) begin
			n_fill_d = n_fill_q + 1'b1;
		end
		if (u_re) begin
			u_fill_d = u_fill_q - 1'b1;
		end
		if (n_re) begin
			n_fill_d = n_fill_q - 1'b1;
		end
		served_d = served_q;
		if (cmd.pop && served_q != '1) begin
			served_d = served_q + 1'b1;
		end
		tick_d = tick_q;
		if (cmd.tick && tick_q != '1) begin
			tick_d = tick_q + 1'b1;
		end
	end

	tcpq_ram #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_urgent_ram (
		.clk   (clk),
		.we    (u_we),
		.waddr (u_tail_q),
		.wdata (wr_entry),
		.re    (u_re),
		.raddr (u_head_q),
		.rdata (u_rdata)
	);

	tcpq_ram #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_normal_ram (
		.clk   (clk),
		.we    (n_we),
		.waddr (n_tail_q),
		.wdata (wr_entry),
		.re    (n_re),
		.raddr (n_head_q),
		.rdata (n_rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			in_q    <= item;
			limit_q <= (item.serve_limit > LIM_W'(MAX_BATCH)) ? LIM_W'(MAX_BATCH)
			                                                   : item.serve_limit;
		end
		if (cmd.pop) begin
			urg_q  <= pop_urg;
			last_q <= ((cnt_q + 1'b1) >= limit_q) || (u_fill_d == '0 && n_fill_d == '0);
		end
		if (cmd.emit_blank) begin
			result <= '{out_id: '0, out_arrival: '0, out_gender: 1'b0, out_urgent: 1'b0,
			            served_valid: 1'b0, last_result: 1'b1,
			            status: (in_q.action == ACT_ADD) ? add_status : ST_OK,
			            urgent_level: LVL_W'(u_fill_d), normal_level: LVL_W'(n_fill_d),
			            served_total: served_d, waiting_total: tick_d};
		end else if (cmd.emit_entry) begin
			result <= '{out_id: rd_entry.id, out_arrival: rd_entry.arrival,
			            out_gender: rd_entry.gender, out_urgent: urg_q,
			            served_valid: 1'b1, last_result: last_q, status: ST_OK,
			            urgent_level: LVL_W'(u_fill_d), normal_level: LVL_W'(n_fill_d),
			            served_total: served_d, waiting_total: tick_d};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q        <= '0;
			u_head_q     <= '0;
			u_tail_q     <= '0;
			n_head_q     <= '0;
			n_tail_q     <= '0;
			u_fill_q     <= '0;
			n_fill_q     <= '0;
			cd_q         <= '0;
			served_q     <= '0;
			tick_q       <= '0;
			result_valid <= 1'b0;
		end else begin
			u_fill_q <= u_fill_d;
			n_fill_q <= n_fill_d;
			served_q <= served_d;
			tick_q   <= tick_d;
			if (cmd.load_in) begin
				cnt_q <= '0;
			end else if (cmd.pop) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (u_we) begin
				u_tail_q <= ptr_next(u_tail_q);
			end
			if (n_we) begin
				n_tail_q <= ptr_next(n_tail_q);
			end
			if (u_re) begin
				u_head_q <= ptr_next(u_head_q);
			end
			if (n_re) begin
				n_head_q <= ptr_next(n_head_q);
			end
			if (cmd.tick && cd_q != 16'sh8000) begin
				cd_q <= cd_q - 16'sd1;
			end else if (cmd.set) begin
				cd_q <= in_q.countdown_value;
			end
			if (cmd.emit_blank || cmd.emit_entry) begin
				result_valid <= 1'b1;
			end else if (result_ready) begin
				result_valid <= 1'b0;
			end
		end
	end

	assign sts = '{action: in_q.action, cd_zero: (cd_q == '0), limit_zero: (limit_q == '0),
	               both_empty: (u_fill_q == '0 && n_fill_q == '0), last: last_q,
	               out_free: out_free};
endmodule

// ===== rtl/tcpq_checker.sv =====
`timescale 1ns / 1ps
module tcpq_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                item_valid,
	input logic                item_ready,
	input tcpq_pkg::in_item_t  item,
	input logic                result_valid,
	input logic                result_ready,
	input tcpq_pkg::out_item_t result
);
	import tcpq_pkg::*;

	// hold a stalled transaction
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result dropped or changed while stalled");

	a_blank_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.served_valid |-> result.last_result &&
		result.out_id == '0 && !result.out_urgent)
		else $error("non-serving result not final or not blank");

	a_served_ok: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.served_valid |-> result.status == ST_OK)
		else $error("served entry with error status");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.status == ST_OK || result.status == ST_BAD_ID ||
		result.status == ST_FULL)
		else $error("undefined status code");
endmodule

bind two_class_priority_queue_server tcpq_checker u_tcpq_checker (.*);
